FILE: hw/rtl/gpe_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad press-edge package
// Shared types, register codes and constants of the gamepad press-edge block.
// ----------------------------------------------------------------------------
package gpe_pkg;

  // Default sizes
  localparam int NUM_PORTS_DEF = 2;
  localparam int TIME_BITS_DEF = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_REPEAT_MODE,
    REG_PAD_KIND_PORT0,
    REG_PAD_KIND_PORT1,
    REG_INITIAL_DELAY,
    REG_FAST_PERIOD,
    REG_SLOW_EXTRA,
    REG_SLOW_COUNT
  } gpe_reg_e;

  // Register reset values
  localparam logic        RST_REPEAT_MODE   = 1'b1;
  localparam logic [1:0]  RST_PAD_KIND      = 2'd0;
  localparam logic [15:0] RST_INITIAL_DELAY = 16'd400;
  localparam logic [15:0] RST_FAST_PERIOD   = 16'd40;
  localparam logic [15:0] RST_SLOW_EXTRA    = 16'd43;
  localparam logic [4:0]  RST_SLOW_COUNT    = 5'd20;

  // Controller kind code that enables stick scanning
  localparam logic [1:0] PAD_ANALOG = 2'd2;

  // Stick thresholds and repeat counter ceiling
  localparam logic [7:0] STICK_HI   = 8'hbf;
  localparam logic [7:0] STICK_LO   = 8'h40;
  localparam logic [4:0] REPEAT_MAX = 5'd31;

  // Direction bit positions, in scan order
  localparam int DIR_RH_HI = 16;
  localparam int DIR_RH_LO = 17;
  localparam int DIR_RV_LO = 18;
  localparam int DIR_RV_HI = 19;
  localparam int DIR_LH_HI = 20;
  localparam int DIR_LH_LO = 21;
  localparam int DIR_LV_LO = 22;
  localparam int DIR_LV_HI = 23;

  typedef struct packed {
    logic        port;
    logic        pad_ready;
    logic        read_ok;
    logic [15:0] buttons_raw;
    logic [7:0]  right_stick_h;
    logic [7:0]  right_stick_v;
    logic [7:0]  left_stick_h;
    logic [7:0]  left_stick_v;
    logic [31:0] now_ms;
  } gpe_in_t;

  typedef struct packed {
    logic [23:0] port_held;
    logic [23:0] port_new;
    logic [23:0] held_all;
    logic [23:0] new_all;
    logic [6:0]  stick_level;
  } gpe_out_t;

endpackage

FILE: hw/rtl/gpe_stream_if.sv
// ----------------------------------------------------------------------------
// Gamepad press-edge stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface gpe_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

FILE: hw/rtl/gamepad_press_edge_autorepeat.sv
// ----------------------------------------------------------------------------
// Gamepad press-edge detector with auto-repeat
// Inverts controller samples, maps analog sticks to direction bits and
// reports held buttons, new presses and typematic repeats per port.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload     Transaction
//  -------  ---  ----------  ------------------------------------------
//  in_i     in   gpe_in_t    one controller sample from one port
//  out_o    out  gpe_out_t   one result per accepted sample
//  APB      in   32-bit reg  register write/read, byte address 4*index
//
//  One sample is taken every cycle while in_i.ready is high; the sample lands
//  in the input register at its accepting edge and its result is offered
//  from the result register, once that register is free. The per-port state
//  update is one pass of logic between those registers.
//  A stalled result holds in the result register while one further sample
//  waits in the input register; only then does in_i.ready drop.
//  Reset clears all port state, the scan toggle and the stick level at once.
//
module gamepad_press_edge_autorepeat #(
  parameter int NUM_PORTS = gpe_pkg::NUM_PORTS_DEF,
  parameter int TIME_BITS = gpe_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gpe_stream_if.sink                      in_i,
  gpe_stream_if.source                    out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gpe_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [gpe_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [gpe_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import gpe_pkg::*;

  localparam int TW = TIME_BITS;

  // Configuration registers
  logic        repeat_mode_q;
  logic [1:0]  pad_kind0_q;
  logic [1:0]  pad_kind1_q;
  logic [15:0] initial_delay_q;
  logic [15:0] fast_period_q;
  logic [15:0] slow_extra_q;
  logic [4:0]  slow_count_q;

  logic     cfg_wr;
  gpe_reg_e cfg_idx;

  // Pipeline
  logic    in_valid_q;
  gpe_in_t in_data_q;
  logic    out_valid_q;
  gpe_out_t out_data_q;
  gpe_out_t out_data_d;
  logic    advance;

  // Port state
  logic [23:0]   held_q  [NUM_PORTS];
  logic [23:0]   held_d  [NUM_PORTS];
  logic [23:0]   last_q  [NUM_PORTS];
  logic [23:0]   last_d  [NUM_PORTS];
  logic [23:0]   new_q   [NUM_PORTS];
  logic [23:0]   new_d   [NUM_PORTS];
  logic [TW-1:0] due_q   [NUM_PORTS];
  logic [TW-1:0] due_d   [NUM_PORTS];
  logic [4:0]    count_q [NUM_PORTS];
  logic [4:0]    count_d [NUM_PORTS];
  logic          toggle_q;
  logic          toggle_d;
  logic [6:0]    level_q;
  logic [6:0]    level_d;

  // Per-sample decode
  logic          port_ok;
  logic          analog;
  logic          take;
  logic          scan_now;
  logic          scan_hit;
  logic [23:0]   scan_dir;
  logic [6:0]    scan_level;
  logic [23:0]   held_word;
  logic [TW-1:0] now_t;

  // --------------------------------------------------------------------------
  // APB register file
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = gpe_reg_e'(paddr[CFG_ADDR_W-1:2]);

  // Write a register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_mode_q   <= RST_REPEAT_MODE;
      pad_kind0_q     <= RST_PAD_KIND;
      pad_kind1_q     <= RST_PAD_KIND;
      initial_delay_q <= RST_INITIAL_DELAY;
      fast_period_q   <= RST_FAST_PERIOD;
      slow_extra_q    <= RST_SLOW_EXTRA;
      slow_count_q    <= RST_SLOW_COUNT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_REPEAT_MODE:    repeat_mode_q   <= pwdata[0];
        REG_PAD_KIND_PORT0: pad_kind0_q     <= pwdata[1:0];
        REG_PAD_KIND_PORT1: pad_kind1_q     <= pwdata[1:0];
        REG_INITIAL_DELAY:  initial_delay_q <= pwdata[15:0];
        REG_FAST_PERIOD:    fast_period_q   <= pwdata[15:0];
        REG_SLOW_EXTRA:     slow_extra_q    <= pwdata[15:0];
        REG_SLOW_COUNT:     slow_count_q    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_REPEAT_MODE:    prdata = CFG_DATA_W'(repeat_mode_q);
      REG_PAD_KIND_PORT0: prdata = CFG_DATA_W'(pad_kind0_q);
      REG_PAD_KIND_PORT1: prdata = CFG_DATA_W'(pad_kind1_q);
      REG_INITIAL_DELAY:  prdata = CFG_DATA_W'(initial_delay_q);
      REG_FAST_PERIOD:    prdata = CFG_DATA_W'(fast_period_q);
      REG_SLOW_EXTRA:     prdata = CFG_DATA_W'(slow_extra_q);
      REG_SLOW_COUNT:     prdata = CFG_DATA_W'(slow_count_q);
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register and result handshake
  // --------------------------------------------------------------------------
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // Capture a new sample whenever the input stage is free
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_data_q <= in_i.payload;
    end
  end

  // --------------------------------------------------------------------------
  // Sample decode and stick scan
  // --------------------------------------------------------------------------
  assign port_ok  = int'(in_data_q.port) < NUM_PORTS;
  assign analog   = repeat_mode_q &&
                    ((in_data_q.port ? pad_kind1_q : pad_kind0_q) == PAD_ANALOG);
  assign take     = advance && port_ok && in_data_q.pad_ready && in_data_q.read_ok;
  assign scan_now = take && analog && toggle_q;
  assign toggle_d = toggle_q ^ (take && analog);
  assign now_t    = TW'(in_data_q.now_ms);

  // Check the sticks in fixed order; the first one past a threshold wins
  always_comb begin
    scan_hit   = 1'b1;
    scan_dir   = '0;
    scan_level = '0;
    priority if (in_data_q.right_stick_h >= STICK_HI) begin
      scan_dir   = 24'b1 << DIR_RH_HI;
      scan_level = 7'(in_data_q.right_stick_h - STICK_HI);
    end else if (in_data_q.right_stick_h <= STICK_LO) begin
      scan_dir   = 24'b1 << DIR_RH_LO;
      scan_level = 7'(STICK_LO - in_data_q.right_stick_h);
    end else if (in_data_q.right_stick_v <= STICK_LO) begin
      scan_dir   = 24'b1 << DIR_RV_LO;
      scan_level = 7'(STICK_LO - in_data_q.right_stick_v);
    end else if (in_data_q.right_stick_v >= STICK_HI) begin
      scan_dir   = 24'b1 << DIR_RV_HI;
      scan_level = 7'(in_data_q.right_stick_v - STICK_HI);
    end else if (in_data_q.left_stick_h >= STICK_HI) begin
      scan_dir   = 24'b1 << DIR_LH_HI;
      scan_level = 7'(in_data_q.left_stick_h - STICK_HI);
    end else if (in_data_q.left_stick_h <= STICK_LO) begin
      scan_dir   = 24'b1 << DIR_LH_LO;
      scan_level = 7'(STICK_LO - in_data_q.left_stick_h);
    end else if (in_data_q.left_stick_v <= STICK_LO) begin
      scan_dir   = 24'b1 << DIR_LV_LO;
      scan_level = 7'(STICK_LO - in_data_q.left_stick_v);
    end else if (in_data_q.left_stick_v >= STICK_HI) begin
      scan_dir   = 24'b1 << DIR_LV_HI;
      scan_level = 7'(in_data_q.left_stick_v - STICK_HI);
    end else begin
      scan_hit = 1'b0;
    end
  end

  // Invert the buttons, or substitute the stick direction
  assign held_word = (scan_now && scan_hit) ? scan_dir : {8'b0, ~in_data_q.buttons_raw};
  assign level_d   = scan_now ? scan_level : level_q;

  // --------------------------------------------------------------------------
  // Per-port edge and repeat update
  // --------------------------------------------------------------------------
  always_comb begin
    logic [TW-1:0] diff;
    logic          passed;
    logic [TW-1:0] slow_add;
    diff     = '0;
    passed   = 1'b0;
    slow_add = '0;
    for (int q = 0; q < NUM_PORTS; q++) begin
      held_d[q]  = held_q[q];
      last_d[q]  = last_q[q];
      new_d[q]   = new_q[q];
      due_d[q]   = due_q[q];
      count_d[q] = count_q[q];
      diff       = now_t - due_q[q];
      passed     = (diff != '0) && !diff[TW-1];
      slow_add   = (count_q[q] < slow_count_q) ? TW'(slow_extra_q) : '0;
      if (advance && port_ok && (int'(in_data_q.port) == q)) begin
        if (!in_data_q.pad_ready) begin
          new_d[q] = '0;
        end else if (in_data_q.read_ok) begin
          held_d[q] = held_word;
          new_d[q]  = held_word & ~last_q[q];
          if (repeat_mode_q) begin
            if (last_q[q] == held_word) begin
              // Steady hold: fire a repeat once the due time has passed
              if (passed) begin
                new_d[q] = held_word;
                due_d[q] = now_t + TW'(fast_period_q) + slow_add;
                if (count_q[q] != REPEAT_MAX) begin
                  count_d[q] = count_q[q] + 5'd1;
                end
              end
            end else begin
              // Changed word: restart the initial delay
              count_d[q] = '0;
              due_d[q]   = now_t + TW'(initial_delay_q);
              last_d[q]  = held_word;
            end
          end else begin
            last_d[q] = held_word;
          end
        end
      end
    end
  end

  // Hold port state; unselected ports keep their values through the _d path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < NUM_PORTS; q++) begin
        held_q[q]  <= '0;
        last_q[q]  <= '0;
        new_q[q]   <= '0;
        due_q[q]   <= '0;
        count_q[q] <= '0;
      end
      toggle_q <= 1'b0;
      level_q  <= '0;
    end else begin
      for (int q = 0; q < NUM_PORTS; q++) begin
        held_q[q]  <= held_d[q];
        last_q[q]  <= last_d[q];
        new_q[q]   <= new_d[q];
        due_q[q]   <= due_d[q];
        count_q[q] <= count_d[q];
      end
      toggle_q <= toggle_d;
      level_q  <= level_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result assembly and result register
  // --------------------------------------------------------------------------
  always_comb begin
    out_data_d             = '0;
    out_data_d.stick_level = level_d;
    for (int q = 0; q < NUM_PORTS; q++) begin
      out_data_d.held_all = out_data_d.held_all | held_d[q];
      out_data_d.new_all  = out_data_d.new_all | new_d[q];
      if (port_ok && (int'(in_data_q.port) == q)) begin
        out_data_d.port_held = held_d[q];
        out_data_d.port_new  = new_d[q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

endmodule

FILE: hw/rtl/gpe_checker.sv
// ----------------------------------------------------------------------------
// Gamepad press-edge checker
// Port-level assertions on the result channel of the press-edge block.
// ----------------------------------------------------------------------------
module gpe_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input gpe_pkg::gpe_out_t out_payload_i
);

  import gpe_pkg::*;

  // Keep a stalled result on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Keep a stalled result unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_payload_i))
    else $error("result changed while stalled");

  // Port word must be contained in the all-ports word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_payload_i.port_held & ~out_payload_i.held_all) == 24'd0)
    else $error("port_held not covered by held_all");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_payload_i.port_new & ~out_payload_i.new_all) == 24'd0)
    else $error("port_new not covered by new_all");

  // Stick level never exceeds full deflection
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_payload_i.stick_level <= 7'd64)
    else $error("stick_level out of range");

endmodule

bind gamepad_press_edge_autorepeat gpe_checker u_gpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
